// ===== hdl/qte_pkg.sv =====
package qte_pkg;

	localparam int COMPONENT_WIDTH = 16;
	localparam int CORDIC_STAGES = 16;

	localparam int WORK_FRAC = 28;
	localparam int TABLE_LEN = 30;
	localparam int CORDIC_N = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

	// product alignment to Q.28
	localparam int PROD_SHIFT = 2 * (COMPONENT_WIDTH - 2) - WORK_FRAC;
	localparam int PROD_SHR = (PROD_SHIFT > 0) ? PROD_SHIFT : 0;
	localparam int PROD_SHL = (PROD_SHIFT < 0) ? -PROD_SHIFT : 0;
	localparam int PROD_EXT_W = 2 * COMPONENT_WIDTH + PROD_SHL;

	localparam int PROD_W = WORK_FRAC + 4;
	localparam int SUM_W = WORK_FRAC + 6;
	localparam int CW = SUM_W + 2;
	localparam int ZW = 32;
	localparam int SQ_W = WORK_FRAC + 1;
	localparam int ISQ_W = 2 * WORK_FRAC + 2;
	localparam int ISQ_STEPS = WORK_FRAC + 1;
	localparam int RND_W = ZW - 15;

	typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [CW-1:0] cw_t;
	typedef logic signed [ZW-1:0] ang_t;
	typedef logic [ISQ_W-1:0] isq_t;
	typedef logic signed [14:0] q12_t;

	localparam sum_t ONE_Q28 = sum_t'(64'sd1 << WORK_FRAC);
	localparam isq_t ONE2_Q56 = isq_t'(1) << (2 * WORK_FRAC);
	localparam ang_t PI_Q28 = 32'sd843314857;
	localparam q12_t HALF_PI_Q12 = 15'sd6434;
	localparam q12_t PI_Q12 = 15'sd12868;
	localparam logic signed [ZW:0] ROUND_HALF = (ZW + 1)'(1) << (WORK_FRAC - 13);

	localparam ang_t ATAN_TAB [TABLE_LEN] = '{
		32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
		32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
		32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384,
		32'sd8192, 32'sd4096, 32'sd2048, 32'sd1024, 32'sd512,
		32'sd256, 32'sd128, 32'sd64, 32'sd32, 32'sd16,
		32'sd8, 32'sd4, 32'sd2, 32'sd1, 32'sd0
	};

	typedef struct packed {
		sum_t roll_y;
		sum_t roll_x;
		sum_t yaw_y;
		sum_t yaw_x;
		sum_t pitch_s;
		logic clamp;
		logic neg;
	} side_t;

	typedef struct packed {
		logic clamp;
		logic neg;
	} tag_t;

	function automatic prod_t prod_q28(input comp_t a, input comp_t b);
		logic signed [2*COMPONENT_WIDTH-1:0] p;
		logic signed [PROD_EXT_W-1:0] e;
		p = a * b;
		e = PROD_EXT_W'(p);
		e = (e >>> PROD_SHR) <<< PROD_SHL;
		return e[PROD_W-1:0];
	endfunction

	// round half up to Q3.12, then saturate to +/-lim
	function automatic q12_t to_q12(input ang_t a, input q12_t lim);
		logic signed [ZW:0] t;
		logic signed [RND_W-1:0] r;
		logic signed [RND_W-1:0] l;
		t = (ZW + 1)'(a) + ROUND_HALF;
		r = RND_W'(t >>> (WORK_FRAC - 12));
		l = RND_W'(lim);
		if (r > l)
			return lim;
		if (r < -l)
			return -lim;
		return r[14:0];
	endfunction

endpackage

// ===== hdl/quaternion_to_euler_angles_top.sv =====
// Pipeline: 3 product/sum stages, 29 square-root stages, 17 CORDIC stages,
// 1 rounding stage.
// Throughput: one quaternion per cycle; the whole pipeline advances while the
// output register is empty or being taken, so a stall holds every stage.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
module quaternion_to_euler_angles_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  qte_pkg::comp_t quat_w,
	input  qte_pkg::comp_t quat_x,
	input  qte_pkg::comp_t quat_y,
	input  qte_pkg::comp_t quat_z,
	output logic           out_valid,
	input  logic           out_ready,
	output logic signed [14:0] roll_angle,
	output logic signed [13:0] pitch_angle,
	output logic signed [14:0] yaw_angle,
	output logic           pitch_clamped
);
	import qte_pkg::*;

	logic en;
	logic fr_valid, sq_valid, co_valid;
	isq_t fr_rad;
	side_t fr_side, sq_side;
	logic [SQ_W-1:0] sq_root;
	ang_t roll_z, pitch_z, yaw_z;
	tag_t pitch_tag;
	tag_t no_tag;
	q12_t pitch_c;

	logic out_valid_q;
	q12_t roll_q, yaw_q;
	logic signed [13:0] pitch_q;
	logic clamp_q;

	assign en = !out_valid_q || out_ready;
	assign in_ready = en;
	assign no_tag = '0;

	qte_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (in_valid),
		.w_i     (quat_w),
		.x_i     (quat_x),
		.y_i     (quat_y),
		.z_i     (quat_z),
		.valid_o (fr_valid),
		.rad_o   (fr_rad),
		.side_o  (fr_side)
	);

	qte_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (fr_valid),
		.rad_i   (fr_rad),
		.side_i  (fr_side),
		.valid_o (sq_valid),
		.root_o  (sq_root),
		.side_o  (sq_side)
	);

	qte_cordic u_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (sq_valid),
		.y_i     (sq_side.roll_y),
		.x_i     (sq_side.roll_x),
		.tag_i   (no_tag),
		.valid_o (co_valid),
		.angle_o (roll_z),
		.tag_o   ()
	);

	qte_cordic u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (sq_valid),
		.y_i     (sq_side.pitch_s),
		.x_i     (sum_t'({1'b0, sq_root})),
		.tag_i   ({sq_side.clamp, sq_side.neg}),
		.valid_o (),
		.angle_o (pitch_z),
		.tag_o   (pitch_tag)
	);

	qte_cordic u_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (sq_valid),
		.y_i     (sq_side.yaw_y),
		.x_i     (sq_side.yaw_x),
		.tag_i   (no_tag),
		.valid_o (),
		.angle_o (yaw_z),
		.tag_o   ()
	);

	always_comb begin
		if (pitch_tag.clamp)
			pitch_c = pitch_tag.neg ? -HALF_PI_Q12 : HALF_PI_Q12;
		else
			pitch_c = to_q12(pitch_z, HALF_PI_Q12);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= co_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q <= to_q12(roll_z, PI_Q12);
			yaw_q <= to_q12(yaw_z, PI_Q12);
			pitch_q <= pitch_c[13:0];
			clamp_q <= pitch_tag.clamp;
		end
	end

	assign out_valid = out_valid_q;
	assign roll_angle = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle = yaw_q;
	assign pitch_clamped = clamp_q;

endmodule

// ===== hdl/qte_front.sv =====
module qte_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_i,
	input  qte_pkg::comp_t    w_i,
	input  qte_pkg::comp_t    x_i,
	input  qte_pkg::comp_t    y_i,
	input  qte_pkg::comp_t    z_i,
	output logic              valid_o,
	output qte_pkg::isq_t     rad_o,
	output qte_pkg::side_t    side_o
);
	import qte_pkg::*;

	prod_t wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	side_t side_s2, side_s3;
	isq_t rad_s3;
	logic [2:0] vld_q;
	logic [SQ_W-1:0] s_abs;
	logic [2*SQ_W-1:0] s_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[1:0], valid_i};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= prod_q28(w_i, x_i);
			yz_s1 <= prod_q28(y_i, z_i);
			xx_s1 <= prod_q28(x_i, x_i);
			yy_s1 <= prod_q28(y_i, y_i);
			wy_s1 <= prod_q28(w_i, y_i);
			zx_s1 <= prod_q28(z_i, x_i);
			wz_s1 <= prod_q28(w_i, z_i);
			xy_s1 <= prod_q28(x_i, y_i);
			zz_s1 <= prod_q28(z_i, z_i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.roll_y  <= (sum_t'(wx_s1) + sum_t'(yz_s1)) <<< 1;
			side_s2.roll_x  <= ONE_Q28 - ((sum_t'(xx_s1) + sum_t'(yy_s1)) <<< 1);
			side_s2.yaw_y   <= (sum_t'(wz_s1) + sum_t'(xy_s1)) <<< 1;
			side_s2.yaw_x   <= ONE_Q28 - ((sum_t'(yy_s1) + sum_t'(zz_s1)) <<< 1);
			side_s2.pitch_s <= (sum_t'(wy_s1) - sum_t'(zx_s1)) <<< 1;
			side_s2.clamp   <= 1'b0;
			side_s2.neg     <= 1'b0;
		end
	end

	// magnitude only meaningful below one; clamped items ignore the root
	always_comb begin
		s_abs = side_s2.pitch_s[SUM_W-1] ? SQ_W'(-side_s2.pitch_s) : SQ_W'(side_s2.pitch_s);
		s_sq = s_abs * s_abs;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.roll_y  <= side_s2.roll_y;
			side_s3.roll_x  <= side_s2.roll_x;
			side_s3.yaw_y   <= side_s2.yaw_y;
			side_s3.yaw_x   <= side_s2.yaw_x;
			side_s3.pitch_s <= side_s2.pitch_s;
			side_s3.clamp <= (side_s2.pitch_s >= ONE_Q28) || (side_s2.pitch_s <= -ONE_Q28);
			side_s3.neg <= side_s2.pitch_s[SUM_W-1];
			rad_s3 <= ONE2_Q56 - isq_t'(s_sq);
		end
	end

	assign valid_o = vld_q[2];
	assign rad_o = rad_s3;
	assign side_o = side_s3;

endmodule

// ===== hdl/qte_isqrt.sv =====
module qte_isqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_i,
	input  qte_pkg::isq_t  rad_i,
	input  qte_pkg::side_t side_i,
	output logic           valid_o,
	output logic [qte_pkg::SQ_W-1:0] root_o,
	output qte_pkg::side_t side_o
);
	import qte_pkg::*;

	isq_t rem_s [ISQ_STEPS];
	isq_t root_s [ISQ_STEPS];
	side_t side_s [ISQ_STEPS];
	logic [ISQ_STEPS-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[ISQ_STEPS-2:0], valid_i};
	end

	// one result bit per stage, starting from the top power of four
	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
		localparam isq_t BIT = isq_t'(1) << (2 * (ISQ_STEPS - 1 - k));
		isq_t rem_c, root_c;
		side_t side_c;
		if (k == 0) begin : g_first
			assign rem_c = rad_i;
			assign root_c = '0;
			assign side_c = side_i;
		end else begin : g_next
			assign rem_c = rem_s[k-1];
			assign root_c = root_s[k-1];
			assign side_c = side_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_c;
				if (rem_c >= root_c + BIT) begin
					rem_s[k] <= rem_c - root_c - BIT;
					root_s[k] <= (root_c >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_c;
					root_s[k] <= root_c >> 1;
				end
			end
		end
	end

	assign valid_o = vld_q[ISQ_STEPS-1];
	assign root_o = root_s[ISQ_STEPS-1][SQ_W-1:0];
	assign side_o = side_s[ISQ_STEPS-1];

endmodule

// ===== hdl/qte_cordic.sv =====
module qte_cordic (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_i,
	input  qte_pkg::sum_t y_i,
	input  qte_pkg::sum_t x_i,
	input  qte_pkg::tag_t tag_i,
	output logic          valid_o,
	output qte_pkg::ang_t angle_o,
	output qte_pkg::tag_t tag_o
);
	import qte_pkg::*;

	cw_t x_s [CORDIC_N+1];
	cw_t y_s [CORDIC_N+1];
	ang_t z_s [CORDIC_N+1];
	logic zero_s [CORDIC_N+1];
	tag_t tag_s [CORDIC_N+1];
	logic [CORDIC_N:0] vld_q;
	cw_t x_ext, y_ext;

	assign x_ext = cw_t'(x_i);
	assign y_ext = cw_t'(y_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[CORDIC_N-1:0], valid_i};
	end

	// left half plane: turn by pi first
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_i == '0) && (y_i == '0);
			tag_s[0] <= tag_i;
			if (x_i[SUM_W-1]) begin
				x_s[0] <= -x_ext;
				y_s[0] <= -y_ext;
				z_s[0] <= y_i[SUM_W-1] ? -PI_Q28 : PI_Q28;
			end else begin
				x_s[0] <= x_ext;
				y_s[0] <= y_ext;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				tag_s[i+1] <= tag_s[i];
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_TAB[i];
				end
			end
		end
	end

	assign valid_o = vld_q[CORDIC_N];
	assign angle_o = zero_s[CORDIC_N] ? '0 : z_s[CORDIC_N];
	assign tag_o = tag_s[CORDIC_N];

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import qte_pkg::*;

	localparam int LATENCY = 50;
	localparam int HOLDOFF_CYCLES = 150;
	localparam longint ONE28 = 64'sd1 << 28;
	localparam longint PI28 = 64'sd843314857;

	typedef struct {
		logic signed [14:0] roll;
		logic signed [13:0] pitch;
		logic signed [14:0] yaw;
		logic               clamped;
	} euler_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	comp_t quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [14:0] roll_angle;
	logic signed [13:0] pitch_angle;
	logic signed [14:0] yaw_angle;
	logic pitch_clamped;

	euler_t angles_due[$];
	int errors = 0;
	bit src_idle_en = 1'b1;
	bit sink_idle_en = 1'b1;
	int sink_holdoff = 0;
	int holdoff_reqs = 0;
	int holdoff_seen = 0;

	longint atan_lut[30] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
		4193963, 2097109, 1048571, 524287, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048,
		1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0
	};

	quaternion_to_euler_angles_top u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#200000000;
		$display("FAIL");
		$finish;
	end

	// Q1.14 times Q1.14 is already Q.28, so no shift is needed, matching the hardware
	function automatic longint mul_q28(longint a, longint b);
		return a * b;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI28 : -PI28;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_lut[i];
			end else begin
				x -= ys; y += xs; z -= atan_lut[i];
			end
		end
		return z;
	endfunction

	function automatic longint round_q12(longint a, longint lim);
		longint r;
		r = (a + (64'sd1 << 15)) >>> 16;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic longint root_floor(bit [63:0] v);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic euler_t euler_of(comp_t qw, comp_t qx, comp_t qy, comp_t qz);
		longint w, x, y, z, s, c;
		euler_t e;
		w = qw; x = qx; y = qy; z = qz;
		e.roll = 15'(round_q12(vector_angle(2 * (mul_q28(w, x) + mul_q28(y, z)),
			ONE28 - 2 * (mul_q28(x, x) + mul_q28(y, y))), 12868));
		s = 2 * (mul_q28(w, y) - mul_q28(z, x));
		e.clamped = 1'b0;
		if (s >= ONE28) begin
			e.pitch = 14'sd6434; e.clamped = 1'b1;
		end else if (s <= -ONE28) begin
			e.pitch = -14'sd6434; e.clamped = 1'b1;
		end else begin
			c = root_floor((64'd1 << 56) - 64'(s * s));
			e.pitch = 14'(round_q12(vector_angle(s, c), 6434));
		end
		e.yaw = 15'(round_q12(vector_angle(2 * (mul_q28(w, z) + mul_q28(x, y)),
			ONE28 - 2 * (mul_q28(y, y) + mul_q28(z, z))), 12868));
		return e;
	endfunction

	// valid stays high after a transaction until the next idle cycle or a drain
	task automatic send_quat(comp_t w, comp_t x, comp_t y, comp_t z);
		while (src_idle_en && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		angles_due.push_back(euler_of(w, x, y, z));
		@(negedge clk);
	endtask

	// unit quaternion from random components, scaled into Q1.14
	task automatic send_unit_quat();
		real a, b, c, n, d;
		a = $urandom_range(2000) / 1000.0 - 1.0;
		b = $urandom_range(2000) / 1000.0 - 1.0;
		c = $urandom_range(2000) / 1000.0 - 1.0;
		d = $urandom_range(2000) / 1000.0 - 1.0;
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n < 0.01) begin
			a = 1.0; n = 1.0;
		end
		send_quat(comp_t'($rtoi(16384.0 * a / n)), comp_t'($rtoi(16384.0 * b / n)),
			comp_t'($rtoi(16384.0 * c / n)), comp_t'($rtoi(16384.0 * d / n)));
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (angles_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed();
		comp_t v[6] = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd16384, -16'sd16384, 16'sd1};
		send_quat(0, 0, 0, 0);
		send_quat(16384, 0, 0, 0);
		send_quat(11585, 0, 11585, 0);   // pitch sine just below one
		send_quat(11585, 0, -11585, 0);
		send_quat(11586, 0, 11586, 0);   // past one
		send_quat(0, 16384, 0, 0);        // roll near pi
		send_quat(0, 0, 0, 16384);
		send_quat(-16384, 0, 0, 1);
		send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
		send_quat(16'sh5555, -16'sh5556, 16'shAAA, -16'sh2AAB);
		for (int i = 0; i < 12; i++)
			send_quat(v[i % 6], v[(i + 1) % 6], v[(i + 3) % 6], v[(i + 2) % 6]);
		wait_drain();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 70)
				send_unit_quat();
			else
				send_quat(comp_t'($urandom), comp_t'($urandom), comp_t'($urandom),
					comp_t'($urandom));
		end
	endtask

	task automatic test_no_idle(int n);
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		test_random(n);
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	task automatic test_backpressure();
		holdoff_reqs++;
		src_idle_en = 1'b0;
		test_random(120);
		src_idle_en = 1'b1;
		wait_drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(700);
		test_no_idle(300);
		test_backpressure();
		test_random(600);
		wait_drain();
		repeat (LATENCY + 20) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	always @(negedge clk) begin
		if (holdoff_seen != holdoff_reqs) begin
			holdoff_seen <= holdoff_reqs;
			sink_holdoff <= HOLDOFF_CYCLES;
			out_ready <= 1'b0;
		end else if (sink_holdoff > 0) begin
			sink_holdoff <= sink_holdoff - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= !(sink_idle_en && $urandom_range(99) < 34);
	end

	always @(posedge clk) begin
		euler_t e;
		if (arst_n && out_valid && out_ready) begin
			if (angles_due.size() == 0) begin
				$error("transaction with no expected result");
				errors++;
			end else begin
				e = angles_due.pop_front();
				if (roll_angle !== e.roll) begin
					$error("roll_angle exp %0d got %0d", e.roll, roll_angle); errors++;
				end
				if (pitch_angle !== e.pitch) begin
					$error("pitch_angle exp %0d got %0d", e.pitch, pitch_angle); errors++;
				end
				if (yaw_angle !== e.yaw) begin
					$error("yaw_angle exp %0d got %0d", e.yaw, yaw_angle); errors++;
				end
				if (pitch_clamped !== e.clamped) begin
					$error("pitch_clamped exp %0b got %0b", e.clamped, pitch_clamped);
					errors++;
				end
			end
		end
	end

endmodule

// ===== files.f =====
hdl/qte_pkg.sv
hdl/qte_front.sv
hdl/qte_isqrt.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler_angles_top.sv
dv/tb_top.sv
